// ===== rtl/core/step_speed_estimator_core_defines.svh =====
// Assertion macros used by the step speed estimator port checker.
// Depends on nothing; included by the checker file.
`ifndef STEP_SPEED_ESTIMATOR_CORE_DEFINES_SVH
`define STEP_SPEED_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sse_pkg.sv =====
// Shared widths, constants, operation codes and state type of the step speed estimator.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package sse_pkg;

    localparam int FUNC_W = 3;
    localparam int TIME_W = 64;
    localparam int LEN_W  = 16;
    localparam int SPD_W  = 24;
    localparam int DUR_W  = 40;
    localparam int SUM_W  = LEN_W + 1;          // sum of two step lengths
    localparam int DEN_W  = DUR_W + 1;          // sum of two step durations
    localparam int K_W    = 34;                 // width of the scale constant
    localparam int PROD_W = SUM_W + K_W;        // numerator width
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 64;

    // Nanoseconds per second times 16 turns Q4.12 metres per ns into Q8.16 m/s.
    localparam logic [K_W-1:0]   NS_X16      = 34'd16000000000;
    localparam logic [DUR_W-1:0] MAX_DUR_RST = 40'd2000000000;

    localparam logic [FUNC_W-1:0] FUNC_STEP   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESET  = 3'd4;

    // Register index as seen on paddr[3].
    localparam logic CFG_IDX_MAX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/sse_mul.sv =====
// Bit-serial multiplier: length sum times the fixed scale (ns per second times 16), MSB first.
// Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sse_pkg::SUM_W-1:0]   i_a,
    output logic [sse_pkg::PROD_W-1:0]  o_prod,
    output logic                        o_done
);

    localparam int CNT_W = $clog2(sse_pkg::SUM_W);

    logic [sse_pkg::PROD_W-1:0] r_acc;
    logic [sse_pkg::SUM_W-1:0]  r_a;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [sse_pkg::PROD_W-1:0] w_add;

    // One multiplier bit per cycle: shift the partial product and add the scale.
    assign w_add = r_a[sse_pkg::SUM_W-1]
                 ? {{(sse_pkg::PROD_W-sse_pkg::K_W){1'b0}}, sse_pkg::NS_X16}
                 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(sse_pkg::SUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
        end else if (r_busy) begin
            r_acc <= {r_acc[sse_pkg::PROD_W-2:0], 1'b0} + w_add;
            r_a   <= {r_a[sse_pkg::SUM_W-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== rtl/core/sse_div.sv =====
// Radix-2 restoring divider with 24-bit saturating quotient.
// Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sse_pkg::PROD_W-1:0]  i_num,
    input  logic [sse_pkg::DEN_W-1:0]   i_den,
    output logic [sse_pkg::SPD_W-1:0]   o_quot,
    output logic                        o_done
);

    localparam int QW    = sse_pkg::SPD_W;
    localparam int DW    = sse_pkg::DEN_W;
    localparam int HI_W  = sse_pkg::PROD_W - QW;
    localparam int CNT_W = $clog2(QW);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0]      w_sh;
    logic [DW+1:0]    w_diff;
    logic             w_borrow;
    logic             w_sat;

    // The quotient fits in 24 bits exactly when the numerator's upper part is below the divisor.
    assign w_sat    = {{(DW-HI_W){1'b0}}, i_num[sse_pkg::PROD_W-1:QW]} >= i_den;
    assign w_sh     = {r_rem, r_q[QW-1]};
    assign w_diff   = {1'b0, w_sh} - {2'b00, r_den};
    assign w_borrow = w_diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
                r_cnt  <= CNT_W'(QW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // The quotient register doubles as the shift register for the low numerator bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= {{(DW-HI_W){1'b0}}, i_num[sse_pkg::PROD_W-1:QW]};
            r_q   <= w_sat ? '1 : i_num[QW-1:0];
        end else if (r_busy) begin
            r_rem <= w_borrow ? w_sh[DW-1:0] : w_diff[DW-1:0];
            r_q   <= {r_q[QW-2:0], !w_borrow};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ===== rtl/core/step_speed_estimator_core.sv =====
// Step speed estimator: top level with control sequencer, state and APB register.
// Depends on sse_pkg, sse_mul and sse_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: func, event time with
//   its known flag, step length and speed. Output channel (o_out_valid /
//   i_out_stall) returns one item per input: speed, last time known, last time.
//   One item is worked on at a time; o_in_stall is low only while the block is idle.
//   A step event that computes a new speed also runs the serial multiplier and then the
//   restoring divider before its result is loaded; a saturating quotient ends the divide
//   early. All other items pass only one wide subtract and one compare stage.
//   The output register holds a result while i_out_stall is high; the next item
//   may already be accepted and worked on, and waits at its end for the register.
//   max_step_duration lives at APB address 0 (64-bit data, low 40 bits used). The user
//   must write it only while the block is idle; the block does not enforce this. Synchronous
//   reset (i_rst_n low) clears the time, speed and step memory, sets max_step_duration
//   to 2e9 ns and empties the output register.
`timescale 1ns / 1ps

module step_speed_estimator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sse_pkg::FUNC_W-1:0]   i_func,
    input  logic [sse_pkg::TIME_W-1:0]   i_event_time,
    input  logic                         i_event_time_known,
    input  logic [sse_pkg::LEN_W-1:0]    i_step_length,
    input  logic [sse_pkg::SPD_W-1:0]    i_speed_in,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sse_pkg::SPD_W-1:0]    o_speed,
    output logic                         o_last_time_known,
    output logic [sse_pkg::TIME_W-1:0]   o_last_time,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sse_pkg::CFG_AW-1:0]   paddr,
    input  logic [sse_pkg::CFG_DW-1:0]   pwdata,
    output logic [sse_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);

    sse_pkg::t_state r_state, n_state;

    // Captured item.
    logic [sse_pkg::FUNC_W-1:0] r_func;
    logic [sse_pkg::TIME_W-1:0] r_t;
    logic                       r_known;
    logic [sse_pkg::LEN_W-1:0]  r_len;
    logic [sse_pkg::SPD_W-1:0]  r_spd;

    // Architectural state.
    logic [sse_pkg::DUR_W-1:0]  r_max;
    logic [sse_pkg::TIME_W-1:0] r_prev_time;
    logic                       r_prev_valid;
    logic [sse_pkg::SPD_W-1:0]  r_cur_speed;
    logic [sse_pkg::LEN_W-1:0]  r_prev_len;
    logic [sse_pkg::DUR_W-1:0]  r_prev_dur;

    // Working registers.
    logic [sse_pkg::TIME_W-1:0] r_gap;
    logic                       r_later;
    logic [sse_pkg::DUR_W-1:0]  r_dur;
    logic [sse_pkg::DEN_W-1:0]  r_den;

    logic                       r_out_valid;
    logic [sse_pkg::SPD_W-1:0]  r_out_speed;
    logic                       r_out_known;
    logic [sse_pkg::TIME_W-1:0] r_out_time;

    logic                        w_accept;
    logic [sse_pkg::TIME_W:0]    w_sub;
    logic                        w_gap_hi;
    logic                        w_gt_max;
    logic                        w_max_nz;
    logic                        w_both;
    logic [sse_pkg::DUR_W-1:0]   w_dur;
    logic                        w_step_go;
    logic [sse_pkg::SUM_W-1:0]   w_len_sum;
    logic                        w_cfg_we;

    logic                        w_mul_start;
    logic                        w_div_start;
    logic                        w_out_load;
    logic [sse_pkg::PROD_W-1:0]  w_prod;
    logic                        w_mul_done;
    logic [sse_pkg::SPD_W-1:0]   w_quot;
    logic                        w_div_done;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_sub     = {1'b0, r_t} - {1'b0, r_prev_time};
    assign w_gap_hi  = |r_gap[sse_pkg::TIME_W-1:sse_pkg::DUR_W];
    assign w_gt_max  = w_gap_hi || (r_gap[sse_pkg::DUR_W-1:0] > r_max);
    assign w_max_nz  = |r_max;
    assign w_both    = r_prev_valid && r_known;
    assign w_dur     = w_gap_hi ? '1 : r_gap[sse_pkg::DUR_W-1:0];
    assign w_len_sum = {1'b0, r_len} + {1'b0, r_prev_len};
    assign w_step_go = (r_func == sse_pkg::FUNC_STEP) && w_both
                     && !(w_max_nz && w_gt_max) && r_later;

    assign w_cfg_we = psel && penable && pwrite && pready
                    && (paddr[3] == sse_pkg::CFG_IDX_MAX);
    assign pready   = 1'b1;
    assign prdata   = (paddr[3] == sse_pkg::CFG_IDX_MAX)
                    ? {{(sse_pkg::CFG_DW-sse_pkg::DUR_W){1'b0}}, r_max} : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sse_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sse_pkg::ST_GAP;
            end
            sse_pkg::ST_GAP: begin
                n_state = sse_pkg::ST_DECIDE;
            end
            sse_pkg::ST_DECIDE: begin
                n_state = w_step_go ? sse_pkg::ST_MUL : sse_pkg::ST_DONE;
            end
            sse_pkg::ST_MUL: begin
                if (w_mul_done) n_state = sse_pkg::ST_DIV;
            end
            sse_pkg::ST_DIV: begin
                if (w_div_done) n_state = sse_pkg::ST_DONE;
            end
            sse_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = sse_pkg::ST_IDLE;
            end
            default: begin
                n_state = sse_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall  = (r_state != sse_pkg::ST_IDLE);
        w_mul_start = (r_state == sse_pkg::ST_DECIDE) && w_step_go;
        w_div_start = (r_state == sse_pkg::ST_MUL) && w_mul_done;
        w_out_load  = (r_state == sse_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_t     <= i_event_time;
            r_known <= i_event_time_known;
            r_len   <= i_step_length;
            r_spd   <= i_speed_in;
        end
        if (r_state == sse_pkg::ST_GAP) begin
            r_gap   <= w_sub[sse_pkg::TIME_W-1:0];
            r_later <= !w_sub[sse_pkg::TIME_W] && (w_sub[sse_pkg::TIME_W-1:0] != '0);
        end
        if (w_mul_start) begin
            r_dur <= w_dur;
            r_den <= {1'b0, w_dur} + {1'b0, r_prev_dur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= sse_pkg::MAX_DUR_RST;
            r_prev_time  <= '0;
            r_prev_valid <= 1'b0;
            r_cur_speed  <= '0;
            r_prev_len   <= '0;
            r_prev_dur   <= '0;
        end else begin
            if (w_cfg_we) begin
                r_max <= pwdata[sse_pkg::DUR_W-1:0];
            end
            if (r_state == sse_pkg::ST_DECIDE) begin
                case (r_func)
                    sse_pkg::FUNC_STEP: begin
                        // Unknown time or an over-long gap drops the speed and restarts timing.
                        if (!w_both || (w_max_nz && w_gt_max)) begin
                            r_cur_speed  <= '0;
                            r_prev_len   <= '0;
                            r_prev_dur   <= '0;
                            r_prev_valid <= r_known;
                            r_prev_time  <= r_known ? r_t : '0;
                        end
                    end
                    sse_pkg::FUNC_REPORT: begin
                        if (!w_both || r_later) begin
                            r_cur_speed  <= r_spd;
                            r_prev_len   <= '0;
                            r_prev_dur   <= '0;
                            r_prev_valid <= r_known;
                            r_prev_time  <= r_known ? r_t : '0;
                        end
                    end
                    sse_pkg::FUNC_QUERY: begin
                        if (w_max_nz && (!w_both || w_gt_max)) begin
                            r_cur_speed <= '0;
                            r_prev_len  <= '0;
                            r_prev_dur  <= '0;
                        end
                    end
                    sse_pkg::FUNC_SET: begin
                        r_cur_speed <= r_spd;
                    end
                    sse_pkg::FUNC_RESET: begin
                        r_cur_speed  <= '0;
                        r_prev_len   <= '0;
                        r_prev_dur   <= '0;
                        r_prev_valid <= 1'b0;
                        r_prev_time  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if ((r_state == sse_pkg::ST_DIV) && w_div_done) begin
                r_cur_speed  <= w_quot;
                r_prev_len   <= r_len;
                r_prev_dur   <= r_dur;
                r_prev_valid <= 1'b1;
                r_prev_time  <= r_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_speed <= r_cur_speed;
            r_out_known <= r_prev_valid;
            r_out_time  <= r_prev_time;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_speed           = r_out_speed;
    assign o_last_time_known = r_out_known;
    assign o_last_time       = r_out_time;

    sse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_len_sum),
        .o_prod  (w_prod),
        .o_done  (w_mul_done)
    );

    sse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

endmodule

// ===== rtl/core/sse_checker.sv =====
// Port-level checker for the step speed estimator, bound to the top level.
// Depends on sse_pkg and step_speed_estimator_core_defines.svh.
`timescale 1ns / 1ps
`include "step_speed_estimator_core_defines.svh"

module sse_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [sse_pkg::SPD_W-1:0]    o_speed,
    input logic                         o_last_time_known,
    input logic [sse_pkg::TIME_W-1:0]   o_last_time
);

    // The block works on one item at a time, so an accepted item closes the input.
    `SSE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "item accepted while busy")

    // An unknown last time is always reported as zero.
    `SSE_ASSERT_NOW(a_time_zero, i_clk, i_rst_n, o_out_valid && !o_last_time_known, o_last_time == '0, "last time not zero while unknown")

    // A stalled result keeps its value.
    `SSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_speed) && $stable(o_last_time), "stalled result changed")

endmodule

bind step_speed_estimator_core sse_checker u_sse_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_speed           (o_speed),
    .o_last_time_known (o_last_time_known),
    .o_last_time       (o_last_time)
);

// ===== tb/step_speed_checker.sv =====
// Checker for the step speed estimator. It watches both item channels and the APB port,
// predicts every result and compares it. Depends on sse_pkg for the operation codes.
`timescale 1ns / 1ps

module step_speed_checker
    import sse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [TIME_W-1:0]   i_event_time,
    input  logic                i_event_time_known,
    input  logic [LEN_W-1:0]    i_step_length,
    input  logic [SPD_W-1:0]    i_speed_in,

    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [SPD_W-1:0]    o_speed,
    input  logic                o_last_time_known,
    input  logic [TIME_W-1:0]   o_last_time,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,

    output int                  o_mismatches,
    output int                  o_outstanding
);

    localparam logic [63:0]       NS_PER_S_X16  = 64'd16_000_000_000;
    localparam logic [DUR_W-1:0]  GAP_LIMIT_RST = 40'd2_000_000_000;
    localparam logic [DUR_W-1:0]  DUR_CEIL      = '1;
    localparam logic [SPD_W-1:0]  SPEED_CEIL    = '1;

    typedef struct packed {
        logic [SPD_W-1:0]   speed;
        logic               known;
        logic [TIME_W-1:0]  stamp;
    } t_estimate;

    t_estimate          pending_estimates[$];
    logic [DUR_W-1:0]   gap_limit;
    logic [TIME_W-1:0]  walk_stamp;
    logic               walk_known;
    logic [SPD_W-1:0]   walk_speed;
    logic [LEN_W-1:0]   step_len_mem;
    logic [DUR_W-1:0]   step_dur_mem;
    int                 mismatch_cnt = 0;
    int                 result_cnt = 0;

    function automatic void forget_speed();
        walk_speed   = '0;
        step_len_mem = '0;
        step_dur_mem = '0;
    endfunction

    function automatic void note_stamp(input logic [TIME_W-1:0] t, input logic known);
        walk_known = known;
        walk_stamp = known ? t : '0;
    endfunction

    function automatic t_estimate estimate_speed(input logic [FUNC_W-1:0] fn,
            input logic [TIME_W-1:0] t, input logic known, input logic [LEN_W-1:0] len,
            input logic [SPD_W-1:0] spd_in);
        logic [63:0]       gap;
        logic [DUR_W-1:0]  dur;
        logic [63:0]       num;
        logic [63:0]       den;
        logic [63:0]       quo;
        t_estimate         est;
        // The gap wraps modulo 2^64, so an older time looks like a very long gap.
        gap = t - walk_stamp;
        case (fn)
            FUNC_STEP: begin
                if (!walk_known || !known || (gap_limit != '0 && gap > 64'(gap_limit))) begin
                    forget_speed();
                    note_stamp(t, known);
                end else if (walk_stamp < t) begin
                    dur = (gap > 64'(DUR_CEIL)) ? DUR_CEIL : gap[DUR_W-1:0];
                    num = (64'(len) + 64'(step_len_mem)) * NS_PER_S_X16;
                    den = 64'(dur) + 64'(step_dur_mem);
                    quo = num / den;
                    walk_speed   = (quo > 64'(SPEED_CEIL)) ? SPEED_CEIL : quo[SPD_W-1:0];
                    step_len_mem = len;
                    step_dur_mem = dur;
                    note_stamp(t, known);
                end
            end
            FUNC_REPORT: begin
                if (!walk_known || !known || t > walk_stamp) begin
                    note_stamp(t, known);
                    walk_speed   = spd_in;
                    step_len_mem = '0;
                    step_dur_mem = '0;
                end
            end
            FUNC_QUERY: begin
                if (gap_limit != '0 && (!walk_known || !known || gap > 64'(gap_limit)))
                    forget_speed();
            end
            FUNC_SET: begin
                walk_speed = spd_in;
            end
            FUNC_RESET: begin
                note_stamp('0, 1'b0);
                forget_speed();
            end
            default: begin
            end
        endcase
        est.speed = walk_speed;
        est.known = walk_known;
        est.stamp = walk_known ? walk_stamp : '0;
        return est;
    endfunction

    function automatic void flag(input string what, input logic [63:0] want,
            input logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("checker: result %0d %s expected %h got %h", result_cnt, what, want, got);
    endfunction

    always @(posedge i_clk) begin : watch
        t_estimate got;
        t_estimate want;
        if (!i_rst_n) begin
            gap_limit = GAP_LIMIT_RST;
            note_stamp('0, 1'b0);
            forget_speed();
            pending_estimates.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[3] == CFG_IDX_MAX)
                gap_limit = pwdata[DUR_W-1:0];
            if (o_out_valid && !i_out_stall) begin
                got = {o_speed, o_last_time_known, o_last_time};
                if (pending_estimates.size() == 0) begin
                    flag("with nothing outstanding, speed", '0, 64'(got.speed));
                end else begin
                    want = pending_estimates.pop_front();
                    if (got.speed !== want.speed)
                        flag("speed", 64'(want.speed), 64'(got.speed));
                    if (got.known !== want.known)
                        flag("last_time_known", 64'(want.known), 64'(got.known));
                    if (got.stamp !== want.stamp)
                        flag("last_time", want.stamp, got.stamp);
                end
                result_cnt++;
            end
            if (i_in_valid && !o_in_stall)
                pending_estimates.push_back(estimate_speed(i_func, i_event_time,
                    i_event_time_known, i_step_length, i_speed_in));
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= pending_estimates.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the step speed estimator testbench: clock, reset, item and APB stimulus, verdict.
// Depends on sse_pkg, step_speed_estimator_core and step_speed_checker.
`timescale 1ns / 1ps

module tb;
    import sse_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int                LONG_HOLD        = 400;
    localparam int                PHASE_ITEMS      = 250;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [TIME_W-1:0]    i_event_time = '0;
    logic                 i_event_time_known = 1'b0;
    logic [LEN_W-1:0]     i_step_length = '0;
    logic [SPD_W-1:0]     i_speed_in = '0;
    logic                 i_out_stall = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [CFG_AW-1:0]    paddr = '0;
    logic [CFG_DW-1:0]    pwdata = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [SPD_W-1:0]     o_speed;
    logic                 o_last_time_known;
    logic [TIME_W-1:0]    o_last_time;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    int                   mismatches;
    int                   outstanding;
    int                   snd_idle_pct = 0;
    int                   rcv_stall_pct = 0;
    logic                 hold_req = 1'b0;
    logic                 hold_used = 1'b0;
    int                   hold_left = 0;
    logic [TIME_W-1:0]    walk_now = '0;

    step_speed_estimator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_func(i_func),
        .i_event_time(i_event_time), .i_event_time_known(i_event_time_known),
        .i_step_length(i_step_length), .i_speed_in(i_speed_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_speed(o_speed),
        .o_last_time_known(o_last_time_known), .o_last_time(o_last_time),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    step_speed_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_func(i_func),
        .i_event_time(i_event_time), .i_event_time_known(i_event_time_known),
        .i_step_length(i_step_length), .i_speed_in(i_speed_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_speed(o_speed),
        .o_last_time_known(o_last_time_known), .o_last_time(o_last_time),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_mismatches(mismatches), .o_outstanding(outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off that lets the block back up.
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used   <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Valid is left high on return so that a following item goes out without a gap.
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] t,
            input logic known, input logic [LEN_W-1:0] len, input logic [SPD_W-1:0] spd);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_func             <= fn;
        i_event_time       <= t;
        i_event_time_known <= known;
        i_step_length      <= len;
        i_speed_in         <= spd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_MAX, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] next_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 64'($urandom_range(1_800_000_000, 200_000_000));
        if (r < 80) return 64'($urandom_range(5000, 1));
        if (r < 87) return {30'd0, 2'($urandom), $urandom};
        if (r < 92) return '0;
        if (r < 97) return -64'($urandom_range(1_000_000, 1));
        return {$urandom, $urandom};
    endfunction

    // Mostly walking sequences of known-time steps; the rest is other operations and noise.
    task automatic send_random_item();
        logic [FUNC_W-1:0] fn;
        logic [TIME_W-1:0] t;
        logic              known;
        int                r;
        r     = $urandom_range(99);
        known = ($urandom_range(19) != 0);
        t     = walk_now + next_gap();
        if (r < 55)
            fn = FUNC_STEP;
        else if (r < 65)
            fn = FUNC_REPORT;
        else if (r < 75)
            fn = FUNC_QUERY;
        else if (r < 82)
            fn = FUNC_SET;
        else if (r < 85)
            fn = FUNC_RESET;
        else if (r < 89)
            fn = 3'($urandom_range(int'(FUNC_SPARE_LAST), int'(FUNC_SPARE_FIRST)));
        else begin
            fn    = 3'($urandom);
            t     = {$urandom, $urandom};
            known = 1'($urandom);
        end
        if (known && (fn == FUNC_STEP || fn == FUNC_REPORT || r >= 89))
            walk_now = t;
        send_item(fn, t, known, 16'($urandom), 24'($urandom));
    endtask

    initial begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [TIME_W-1:0] t0;
        logic [CFG_DW-1:0] limits [4];
        int                idle_tab [4];
        int                stall_tab [4];

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gap limit at its reset value: every operation and the timeout paths.
        t0 = 64'd1000;
        send_item(FUNC_STEP, t0, 1'b1, 16'h1000, '0);
        t0 = t0 + 64'd600_000_000;
        send_item(FUNC_STEP, t0, 1'b1, 16'h0C00, '0);
        send_item(FUNC_STEP, t0 + 64'd1, 1'b1, 16'hFFFF, '0);
        send_item(FUNC_STEP, t0 + 64'd2, 1'b1, 16'hFFFF, '0);
        t0 = t0 + 64'd3_000_000_002;
        send_item(FUNC_STEP, t0, 1'b1, 16'h0400, '0);
        send_item(FUNC_STEP, t0 - 64'd5, 1'b1, 16'h0400, '0);
        send_item(FUNC_SET, '0, 1'b0, '0, 24'hFFFFFF);
        send_item(FUNC_QUERY, t0 + 64'd1_000_000_000, 1'b1, '0, '0);
        send_item(FUNC_QUERY, t0 + 64'd2_100_000_000, 1'b1, '0, '0);
        send_item(FUNC_SET, '0, 1'b1, '0, 24'hFFFFFF);
        send_item(FUNC_QUERY, t0, 1'b0, '0, '0);
        send_item(FUNC_STEP, t0 + 64'd100, 1'b0, 16'h0800, '0);
        send_item(FUNC_REPORT, '0, 1'b0, '0, 24'h123456);
        send_item(FUNC_REPORT, 64'd5000, 1'b1, '0, 24'hFFFFFF);
        send_item(FUNC_REPORT, 64'd4000, 1'b1, '0, 24'h000001);
        send_item(FUNC_REPORT, 64'd5000, 1'b1, '0, 24'h000002);
        send_item(FUNC_REPORT, 64'd6000, 1'b1, '0, '0);
        send_item(FUNC_RESET, '1, 1'b1, '1, '1);
        for (int c = int'(FUNC_SPARE_FIRST); c <= int'(FUNC_SPARE_LAST); c++)
            send_item(3'(c), {$urandom, $urandom}, 1'b1, 16'($urandom), 24'($urandom));
        send_item(FUNC_STEP, '1, 1'b1, '0, '0);

        // Timeout off: older and equal times are ignored, long gaps saturate the duration.
        wait_all_results();
        write_gap_limit('0);
        send_item(FUNC_STEP, '1, 1'b1, 16'h2000, '0);
        send_item(FUNC_QUERY, '0, 1'b0, '0, '0);
        send_item(FUNC_RESET, '0, 1'b0, '0, '0);
        send_item(FUNC_STEP, '0, 1'b1, 16'h1000, '0);
        send_item(FUNC_STEP, 64'h0000_1000_0000_0000, 1'b1, 16'hFFFF, '0);

        // Smallest nonzero limit.
        wait_all_results();
        write_gap_limit(64'd1);
        send_item(FUNC_STEP, 64'd10, 1'b1, 16'h0800, '0);
        send_item(FUNC_STEP, 64'd11, 1'b1, 16'h0800, '0);
        send_item(FUNC_STEP, 64'd13, 1'b1, 16'h0800, '0);

        // Largest limit, with junk in the unused upper data bits.
        wait_all_results();
        write_gap_limit({24'hA5A5A5, 40'hFF_FFFF_FFFF});
        t0 = 64'd13 + 64'h0000_00FF_FFFF_FFFF;
        send_item(FUNC_STEP, t0, 1'b1, 16'h3000, '0);
        send_item(FUNC_STEP, t0 + 64'h0000_0100_0000_0000, 1'b1, 16'h3000, '0);

        limits[0]    = {24'($urandom), 40'($urandom_range(2_100_000_000, 100_000_000))};
        limits[1]    = {24'($urandom), 40'd0};
        limits[2]    = {24'($urandom), 40'hFF_FFFF_FFFF};
        limits[3]    = 64'd2_000_000_000;
        idle_tab[0]  = 0;
        stall_tab[0] = 0;
        idle_tab[1]  = 78;
        stall_tab[1] = 0;
        idle_tab[2]  = 0;
        stall_tab[2] = 78;
        idle_tab[3]  = 18;
        stall_tab[3] = 18;

        for (int ph = 0; ph < 4; ph++) begin
            wait_all_results();
            write_gap_limit(limits[ph]);
            snd_idle_pct  = idle_tab[ph];
            rcv_stall_pct = stall_tab[ph];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 60)
                    hold_req <= 1'b1;
                send_random_item();
            end
        end

        wait_all_results();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
